// ===== src/ddo_pkg.sv =====
// Shared types, constants and tables of the differential-drive odometry block.
`default_nettype none
package ddo_pkg;

	// Number of CORDIC rotations used for cos and sin of the heading (8 to 32).
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_IW = $clog2(CORDIC_STEPS);

	// Datapath widths.
	localparam int AW = 72;
	localparam int TW = 34;
	localparam int MPW = 34;
	localparam int CW = 6;

	localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [28:0] ANG_C = 29'd341782638;

	localparam logic [1:0] CFG_RADIUS = 2'd0;
	localparam logic [1:0] CFG_TRACK = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD = 2'd2;

	localparam logic [15:0] RADIUS_RST = 16'd3277;
	localparam logic [15:0] TRACK_RST = 16'd3604;
	localparam logic [31:0] THRESHOLD_RST = 32'd83886;

	typedef struct packed {
		logic [15:0] radius;
		logic [15:0] track;
		logic [31:0] threshold;
	} ddo_cfg_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] heading;
		logic dropped_frame;
		logic first_sample;
	} ddo_res_t;

	typedef struct packed {
		logic start;
		logic [31:0] angle;
	} ddo_rot_t;

	typedef struct packed {
		logic done;
		logic signed [TW-1:0] cos;
		logic signed [TW-1:0] sin;
	} ddo_trig_t;

	// Arctangent of 2^-i in binary-angle units (2^31 is pi).
	function automatic logic [29:0] atan_at(input logic [4:0] idx);
		logic [29:0] v;
		begin
			case (idx)
				5'd0: v = 30'h20000000;
				5'd1: v = 30'h12E4051E;
				5'd2: v = 30'h09FB385B;
				5'd3: v = 30'h051111D4;
				5'd4: v = 30'h028B0D43;
				5'd5: v = 30'h0145D7E1;
				5'd6: v = 30'h00A2F61E;
				5'd7: v = 30'h00517C55;
				5'd8: v = 30'h0028BE53;
				5'd9: v = 30'h00145F2F;
				5'd10: v = 30'h000A2F98;
				5'd11: v = 30'h000517CC;
				5'd12: v = 30'h00028BE6;
				5'd13: v = 30'h000145F3;
				5'd14: v = 30'h0000A2FA;
				5'd15: v = 30'h0000517D;
				5'd16: v = 30'h000028BE;
				5'd17: v = 30'h0000145F;
				5'd18: v = 30'h00000A30;
				5'd19: v = 30'h00000518;
				5'd20: v = 30'h0000028C;
				5'd21: v = 30'h00000146;
				5'd22: v = 30'h000000A3;
				5'd23: v = 30'h00000051;
				5'd24: v = 30'h00000029;
				5'd25: v = 30'h00000014;
				5'd26: v = 30'h0000000A;
				5'd27: v = 30'h00000005;
				5'd28: v = 30'h00000003;
				5'd29: v = 30'h00000001;
				5'd30: v = 30'h00000001;
				default: v = 30'h00000000;
			endcase
			return v;
		end
	endfunction

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
		logic signed [31:0] r;
		begin
			if (v > 72'sd2147483647) begin
				r = 32'sh7FFFFFFF;
			end else if (v < -72'sd2147483648) begin
				r = 32'sh80000000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/ddo_if.sv =====
// Handshake channel interfaces of the odometry block: samples, poses and configuration.
`default_nettype none
interface ddo_smp_if;
	logic valid;
	logic ready;
	logic signed [15:0] left_speed;
	logic signed [15:0] right_speed;
	logic [31:0] stamp;
	modport source (output valid, left_speed, right_speed, stamp, input ready);
	modport sink (input valid, left_speed, right_speed, stamp, output ready);
endinterface

interface ddo_pose_if;
	logic valid;
	logic ready;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [31:0] heading;
	logic dropped_frame;
	logic first_sample;
	modport source (output valid, pose_x, pose_y, heading, dropped_frame, first_sample,
		input ready);
	modport sink (input valid, pose_x, pose_y, heading, dropped_frame, first_sample,
		output ready);
endinterface

interface ddo_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC giving cos and sin of a binary angle, one step per cycle.
`default_nettype none
module ddo_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input ddo_pkg::ddo_rot_t rot,
	output ddo_pkg::ddo_trig_t trig
);
	import ddo_pkg::*;

	logic signed [TW-1:0] x_q, y_q, z_q;
	logic [CORDIC_IW-1:0] i_q;
	logic run_q, neg_q, done_q;
	logic signed [TW-1:0] cos_q, sin_q;
	logic signed [TW-1:0] z0, zf, xs, ys, at, xn, yn, zn;
	logic last;

	always_comb begin
		z0 = TW'($signed(rot.angle));
		if (z0 >= 34'sd1073741824) begin
			zf = z0 - 34'sd2147483648;
		end else if (z0 < -34'sd1073741824) begin
			zf = z0 + 34'sd2147483648;
		end else begin
			zf = z0;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = TW'(atan_at(5'(i_q)));
		if (!z_q[TW-1]) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - at;
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + at;
		end
		last = (i_q == CORDIC_IW'(CORDIC_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (rot.start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (last) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rot.start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= zf;
			neg_q <= (zf != z0);
		end else if (run_q) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= zn;
			if (last) begin
				cos_q <= neg_q ? -xn : xn;
				sin_q <= neg_q ? -yn : yn;
			end
		end
	end

	assign trig.done = done_q;
	assign trig.cos = cos_q;
	assign trig.sin = sin_q;

`ifndef ASSERT_OFF
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("CORDIC finished without running");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !rot.start)
		else $error("CORDIC restarted while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("CORDIC done held longer than one cycle");
`endif
endmodule
`default_nettype wire

// ===== src/ddo_core.sv =====
// Sequencer and shared 72-bit add/subtract datapath of the odometry update.
`default_nettype none
module ddo_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [15:0] left_speed,
	input wire logic signed [15:0] right_speed,
	input wire logic [31:0] stamp,
	input ddo_pkg::ddo_cfg_t cfg,
	input ddo_pkg::ddo_trig_t trig,
	output ddo_pkg::ddo_rot_t rot,
	output logic idle,
	output logic done,
	output ddo_pkg::ddo_res_t res
);
	import ddo_pkg::*;

	typedef enum logic [12:0] {
		P_IDLE = 13'b0000000000001,
		P_VC   = 13'b0000000000010,
		P_M1   = 13'b0000000000100,
		P_M2   = 13'b0000000001000,
		P_DIV  = 13'b0000000010000,
		P_P    = 13'b0000000100000,
		P_COR  = 13'b0000001000000,
		P_VX   = 13'b0000010000000,
		P_DX   = 13'b0000100000000,
		P_AX   = 13'b0001000000000,
		P_VY   = 13'b0010000000000,
		P_DY   = 13'b0100000000000,
		P_AY   = 13'b1000000000000
	} phase_t;

	phase_t phase_q;
	logic [AW-1:0] acc_q, mcand_q;
	logic [MPW-1:0] mplier_q;
	logic [CW-1:0] cnt_q, len;
	logic neg_all_q, msb_neg_q;
	logic [15:0] rem_q, dmag_q;
	logic dneg_q;
	logic signed [32:0] vc_q;
	logic [31:0] dt_q, prev_q;
	logic signed [31:0] x_q, y_q;
	logic [31:0] h_q;
	logic primed_q, cor_start_q, done_q, dropped_q;
	ddo_res_t res_q;

	logic [AW-1:0] op_a, op_b, sum_w, acc_nx;
	logic sub, last, ge;
	logic [15:0] trk;
	logic signed [16:0] sum_s, diff_s;
	logic [31:0] dt_w;

	always_comb begin
		trk = (cfg.track == 16'd0) ? 16'd1 : cfg.track;
		sum_s = 17'(right_speed) + 17'(left_speed);
		diff_s = 17'(right_speed) - 17'(left_speed);
		dt_w = stamp - prev_q;
		unique case (phase_q)
			P_VC, P_M1: len = CW'(16);
			P_M2: len = CW'(29);
			P_DIV: len = CW'(62);
			P_VX, P_VY: len = CW'(TW);
			default: len = CW'(32);
		endcase
		last = (cnt_q == len - 1'b1);
		unique case (phase_q)
			P_DIV: begin
				op_a = {55'd0, rem_q, mcand_q[61]};
				op_b = {56'd0, trk};
				sub = 1'b1;
			end
			P_AX: begin
				op_a = AW'(x_q);
				op_b = mcand_q;
				sub = 1'b0;
			end
			P_AY: begin
				op_a = AW'(y_q);
				op_b = mcand_q;
				sub = 1'b0;
			end
			default: begin
				op_a = acc_q;
				op_b = mcand_q;
				// The top multiplier bit of a signed operand has negative weight.
				sub = neg_all_q | (msb_neg_q & last);
			end
		endcase
		sum_w = op_a + (sub ? ~op_b : op_b) + AW'(sub);
		acc_nx = mplier_q[0] ? sum_w : acc_q;
		ge = !sum_w[AW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			primed_q <= 1'b0;
			cor_start_q <= 1'b0;
			done_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			h_q <= '0;
		end else begin
			cor_start_q <= 1'b0;
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						primed_q <= 1'b1;
						if (primed_q) begin
							phase_q <= P_VC;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				P_VC: if (last) phase_q <= P_M1;
				P_M1: if (last) phase_q <= P_M2;
				P_M2: if (last) phase_q <= P_DIV;
				P_DIV: if (last) phase_q <= P_P;
				P_P: begin
					if (last) begin
						h_q <= h_q + acc_nx[60:29];
						cor_start_q <= 1'b1;
						phase_q <= P_COR;
					end
				end
				P_COR: if (trig.done) phase_q <= P_VX;
				P_VX: if (last) phase_q <= P_DX;
				P_DX: if (last) phase_q <= P_AX;
				P_AX: begin
					x_q <= sat32($signed(sum_w));
					phase_q <= P_VY;
				end
				P_VY: if (last) phase_q <= P_DY;
				P_DY: if (last) phase_q <= P_AY;
				P_AY: begin
					y_q <= sat32($signed(sum_w));
					done_q <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// Datapath registers; the mux per phase loads the next operation's operands.
	always_ff @(posedge clk) begin
		unique case (phase_q)
			P_IDLE: begin
				if (start) begin
					prev_q <= stamp;
					dt_q <= dt_w;
					dropped_q <= primed_q && (dt_w > cfg.threshold);
					mcand_q <= AW'(sum_s);
					mplier_q <= MPW'(cfg.radius);
					acc_q <= '0;
					cnt_q <= '0;
					neg_all_q <= 1'b0;
					msb_neg_q <= 1'b0;
					dneg_q <= diff_s[16];
					dmag_q <= 16'(diff_s[16] ? -diff_s : diff_s);
				end
			end
			P_DIV: begin
				rem_q <= ge ? sum_w[15:0] : {rem_q[14:0], mcand_q[61]};
				acc_q <= {acc_q[AW-2:0], ge};
				mcand_q <= mcand_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					// Truncating division: the sign of q is applied as subtraction below.
					mcand_q <= {acc_q[AW-2:0], ge};
					mplier_q <= MPW'(dt_q);
					acc_q <= '0;
					cnt_q <= '0;
					neg_all_q <= dneg_q;
				end
			end
			P_COR: begin
				if (trig.done) begin
					mcand_q <= AW'(vc_q);
					mplier_q <= trig.cos;
					msb_neg_q <= 1'b1;
					acc_q <= '0;
					cnt_q <= '0;
				end
			end
			P_AX: begin
				mcand_q <= AW'(vc_q);
				mplier_q <= trig.sin;
				msb_neg_q <= 1'b1;
				acc_q <= '0;
				cnt_q <= '0;
			end
			P_AY: begin
				res_q.pose_x <= x_q;
				res_q.pose_y <= sat32($signed(sum_w));
				res_q.heading <= h_q;
				res_q.dropped_frame <= dropped_q;
				res_q.first_sample <= 1'b0;
			end
			default: begin
				acc_q <= acc_nx;
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					acc_q <= '0;
					cnt_q <= '0;
					unique case (phase_q)
						P_VC: begin
							vc_q <= acc_nx[32:0];
							mcand_q <= AW'(dmag_q);
							mplier_q <= MPW'(cfg.radius);
						end
						P_M1: begin
							mcand_q <= acc_nx;
							mplier_q <= MPW'(ANG_C);
						end
						P_M2: begin
							mcand_q <= acc_nx;
							rem_q <= '0;
						end
						P_P: neg_all_q <= 1'b0;
						P_VX, P_VY: begin
							mcand_q <= AW'($signed(acc_nx) >>> 30);
							mplier_q <= MPW'(dt_q);
							msb_neg_q <= 1'b0;
						end
						P_DX, P_DY: mcand_q <= AW'($signed(acc_nx) >>> 29);
						default: mcand_q <= mcand_q;
					endcase
				end
			end
		endcase
		if (phase_q == P_IDLE && start && !primed_q) begin
			res_q.pose_x <= x_q;
			res_q.pose_y <= y_q;
			res_q.heading <= h_q;
			res_q.dropped_frame <= 1'b0;
			res_q.first_sample <= 1'b1;
		end
	end

	assign rot.start = cor_start_q;
	assign rot.angle = h_q;
	assign idle = (phase_q == P_IDLE) && !done_q;
	assign done = done_q;
	assign res = res_q;

`ifndef ASSERT_OFF
	a_cor_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cor_start_q |-> phase_q == P_COR)
		else $error("CORDIC started outside its phase");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != P_IDLE) |-> !start)
		else $error("Item transfer while an update is in progress");
	a_first_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.first_sample) |-> !res_q.dropped_frame)
		else $error("First sample flagged as dropped frame");
	a_done_primed: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> primed_q)
		else $error("Result produced before the clock was primed");
`endif
endmodule
`default_nettype wire

// ===== src/differential_drive_odometry.sv =====
// Top level of the differential-drive odometry block: configuration, core and result register.
`default_nettype none
// Each sample transfer produces one pose transfer; every later sample advances the pose by
// Euler integration. The first sample after reset only records its stamp, and its pose goes
// through the core's result register and then the output register before it is offered.
// The multiplications take 16, 16, 29 and 32 steps, then 34 and 32 steps for each of x and
// y. With the 62-step restoring division they run one bit per cycle on a single 72-bit adder.
// The CORDIC runs CORDIC_STEPS rotation steps between a registered start and a registered
// done. Each saturating position update is a single state, and after the y update the output
// register takes the result. A new sample is taken once the previous pose has been
// transferred out. Configuration registers are written through the cfg channel, which is
// always ready; write them only while the block is idle.
module differential_drive_odometry (
	input wire logic clk,
	input wire logic arst_n,
	ddo_smp_if.sink smp,
	ddo_pose_if.source pose,
	ddo_cfg_if.sink cfg
);
	import ddo_pkg::*;

	ddo_cfg_t cfg_q;
	ddo_rot_t rot;
	ddo_trig_t trig;
	ddo_res_t res, out_q;
	logic idle, done, out_valid_q, start;

	assign cfg.ready = 1'b1;
	assign smp.ready = idle && !out_valid_q;
	assign start = smp.valid && smp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= RADIUS_RST;
			cfg_q.track <= TRACK_RST;
			cfg_q.threshold <= THRESHOLD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_RADIUS: cfg_q.radius <= cfg.data[15:0];
				CFG_TRACK: cfg_q.track <= cfg.data[15:0];
				CFG_THRESHOLD: cfg_q.threshold <= cfg.data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (pose.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	ddo_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.left_speed(smp.left_speed),
		.right_speed(smp.right_speed),
		.stamp(smp.stamp),
		.cfg(cfg_q),
		.trig(trig),
		.rot(rot),
		.idle(idle),
		.done(done),
		.res(res)
	);

	ddo_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.rot(rot),
		.trig(trig)
	);

	assign pose.valid = out_valid_q;
	assign pose.pose_x = out_q.pose_x;
	assign pose.pose_y = out_q.pose_y;
	assign pose.heading = out_q.heading;
	assign pose.dropped_frame = out_q.dropped_frame;
	assign pose.first_sample = out_q.first_sample;
endmodule
`default_nettype wire
